>>> hdl/sdq_pkg.sv
// Package for the quadgram score unit: sizes, field types, item kinds and the
// command and status words between controller and datapath. No dependencies.
package sdq_pkg;

  localparam int TEXT_MAX       = 65536;
  localparam int ALPHABET_SIZE  = 26;
  localparam int WINDOW_LETTERS = 4;
  localparam int VALUE_BITS     = 24;

  localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int INDEX_BITS  = 19;
  localparam int LETTER_BITS = 5;
  localparam int KIND_BITS   = 2;
  localparam int REF_BITS    = 24;
  localparam int SCORE_BITS  = 24;
  localparam int GRAM_BITS   = 16;
  localparam int SUM_BITS    = 40;
  localparam int SEEN_BITS   = 2;
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  localparam int GRAM_CAP_RAW = TEXT_MAX - WINDOW_LETTERS + 1;
  localparam int GRAM_CAP     = (GRAM_CAP_RAW > 65535) ? 65535 : GRAM_CAP_RAW;

  typedef logic [KIND_BITS-1:0]          kind_t;
  typedef logic [INDEX_BITS-1:0]         table_index_t;
  typedef logic signed [VALUE_BITS-1:0]  value_t;
  typedef logic [LETTER_BITS-1:0]        letter_t;
  typedef logic signed [REF_BITS-1:0]    ref_t;
  typedef logic [SCORE_BITS-1:0]         score_t;
  typedef logic [GRAM_BITS-1:0]          gram_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [SUM_BITS-1:0]           mag_t;
  typedef logic [STEP_BITS-1:0]          step_t;
  typedef logic [SEEN_BITS-1:0]          seen_t;

  localparam kind_t KIND_TABLE  = 2'd0;
  localparam kind_t KIND_KEY    = 2'd1;
  localparam kind_t KIND_LETTER = 2'd2;

  localparam letter_t LETTER_MAX = letter_t'(ALPHABET_SIZE - 1);
  localparam seen_t   SEEN_FULL  = seen_t'(WINDOW_LETTERS - 1);
  localparam gram_t   GRAM_LIMIT = gram_t'(GRAM_CAP);
  localparam step_t   STEP_LAST  = step_t'(SUM_BITS - 1);

  typedef struct packed {
    logic ready;
    logic take_letter;
    logic read_table;
    logic accumulate;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic letter_req;
    logic last_flag;
    logic tally_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/sdq_item_if.sv
// Input channel of the quadgram score unit: valid, ready and one item word.
// Depends on sdq_pkg.
interface sdq_item_if;
  import sdq_pkg::*;

  logic         valid;
  logic         ready;
  kind_t        kind;
  table_index_t table_index;
  value_t       table_value;
  letter_t      key_position;
  letter_t      key_letter;
  letter_t      letter;
  logic         last;

  modport source (output valid, kind, table_index, table_value, key_position, key_letter,
                  letter, last, input ready);
  modport sink (input valid, kind, table_index, table_value, key_position, key_letter,
                letter, last, output ready);
endinterface

>>> hdl/sdq_result_if.sv
// Result channel of the quadgram score unit: valid, ready and one result word.
// Depends on sdq_pkg.
interface sdq_result_if;
  import sdq_pkg::*;

  logic   valid;
  logic   ready;
  score_t score;
  gram_t  gram_total;
  logic   too_short;

  modport source (output valid, score, gram_total, too_short, input ready);
  modport sink (input valid, score, gram_total, too_short, output ready);
endinterface

>>> hdl/sdq_ctrl.sv
// Controller state machine of the quadgram score unit.
// Depends on sdq_pkg; drives the datapath through cmd_t and reads status_t.
module sdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  sdq_pkg::status_t status,
  output sdq_pkg::cmd_t    cmd
);
  import sdq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADDR  = 6'b000010,
    S_ACC   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (status.letter_req) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = status.last_flag ? S_START : S_IDLE;
      end
      S_START: begin
        state_next = status.tally_zero ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.ready       = (state == S_IDLE);
    cmd.take_letter = (state == S_IDLE) && status.letter_req;
    cmd.read_table  = (state == S_ADDR);
    cmd.accumulate  = (state == S_ACC);
    cmd.div_start   = (state == S_START) && !status.tally_zero;
    cmd.emit        = (state == S_FIN) && status.out_free;
  end

endmodule

>>> hdl/sdq_divider.sv
// Restoring divider, one quotient bit per cycle, for the average of a text.
// Depends on sdq_pkg.
module sdq_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sdq_pkg::mag_t dividend,
  input  sdq_pkg::gram_t divisor,
  output logic          done,
  output sdq_pkg::mag_t quotient
);
  import sdq_pkg::*;

  logic  busy;
  step_t step;
  mag_t  work;
  gram_t rem;
  gram_t dsor;

  logic [GRAM_BITS:0]   shifted;
  logic [GRAM_BITS+1:0] trial;

  always_comb begin
    shifted = {rem, work[SUM_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_LAST)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      work <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      step <= step + step_t'(1);
      if (!trial[GRAM_BITS+1]) begin
        rem  <= trial[GRAM_BITS-1:0];
        work <= {work[SUM_BITS-2:0], 1'b1};
      end else begin
        rem  <= shifted[GRAM_BITS-1:0];
        work <= {work[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient = work;

endmodule

>>> hdl/sdq_datapath.sv
// Datapath of the quadgram score unit: key registers, log table memory, window,
// sum and tally, divider and output register. Depends on sdq_pkg, the channel
// interfaces and sdq_divider.
module sdq_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  sdq_pkg::ref_t    cfg_wr_data,
  input  sdq_pkg::cmd_t    cmd,
  output sdq_pkg::status_t status,
  sdq_item_if.sink         item,
  sdq_result_if.source     result
);
  import sdq_pkg::*;

  localparam table_index_t MUL_1 = table_index_t'(ALPHABET_SIZE);
  localparam table_index_t MUL_2 = table_index_t'(ALPHABET_SIZE * ALPHABET_SIZE);
  localparam table_index_t MUL_3 = table_index_t'(ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE);

  value_t  log_table [TABLE_DEPTH];
  letter_t inverse_key [ALPHABET_SIZE];

  ref_t    ref_level;
  letter_t plain;
  logic    last_flag;
  logic [3*LETTER_BITS-1:0] recent_letters;
  seen_t   letters_seen;
  logic    gram_hit;
  value_t  table_word;
  sum_t    score_sum;
  gram_t   gram_tally;

  logic    res_valid;
  score_t  res_score;
  gram_t   res_total;
  logic    res_short;

  letter_t      cipher;
  letter_t      mapped;
  letter_t      mapped_clamped;
  table_index_t gram_index;
  logic         item_fire;
  logic         div_done;
  mag_t         quotient;
  mag_t         sum_mag;
  logic signed [SCORE_BITS:0]   avg;
  logic signed [SCORE_BITS+1:0] diff;
  logic [SCORE_BITS+1:0]        diff_mag;
  score_t                       score_sat;

  assign item_fire = item.valid && item.ready;
  assign item.ready = cmd.ready;

  always_comb begin
    cipher         = (item.letter > LETTER_MAX) ? LETTER_MAX : item.letter;
    mapped         = inverse_key[cipher[LETTER_BITS-1:0]];
    mapped_clamped = (mapped > LETTER_MAX) ? LETTER_MAX : mapped;
    gram_index = table_index_t'(recent_letters[3*LETTER_BITS-1:2*LETTER_BITS]) * MUL_3
               + table_index_t'(recent_letters[2*LETTER_BITS-1:LETTER_BITS]) * MUL_2
               + table_index_t'(recent_letters[LETTER_BITS-1:0]) * MUL_1
               + table_index_t'(plain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_level <= '0;
    end else if (cfg_wr_en) begin
      ref_level <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && (item.kind == KIND_KEY) && (item.key_position <= LETTER_MAX)
        && (item.key_letter <= LETTER_MAX)) begin
      inverse_key[item.key_letter] <= item.key_position;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && (item.kind == KIND_TABLE)
        && (item.table_index < table_index_t'(TABLE_DEPTH))) begin
      log_table[item.table_index] <= item.table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_table) begin
      table_word <= log_table[gram_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_letter) begin
      plain     <= mapped_clamped;
      last_flag <= item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      recent_letters <= '0;
      letters_seen   <= '0;
      gram_hit       <= 1'b0;
      score_sum      <= '0;
      gram_tally     <= '0;
    end else begin
      if (cmd.read_table) begin
        recent_letters <= {recent_letters[2*LETTER_BITS-1:0], plain};
        if (letters_seen == SEEN_FULL) begin
          gram_hit <= (gram_tally < GRAM_LIMIT);
        end else begin
          gram_hit     <= 1'b0;
          letters_seen <= letters_seen + seen_t'(1);
        end
      end
      if (cmd.accumulate && gram_hit) begin
        score_sum  <= score_sum + sum_t'(table_word);
        gram_tally <= gram_tally + gram_t'(1);
      end
    end
  end

  assign sum_mag = score_sum[SUM_BITS-1] ? mag_t'(-score_sum) : mag_t'(score_sum);

  sdq_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (gram_tally),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    avg = score_sum[SUM_BITS-1] ? -$signed({1'b0, quotient[SCORE_BITS-1:0]})
                                :  $signed({1'b0, quotient[SCORE_BITS-1:0]});
    diff     = (SCORE_BITS+2)'(avg) - (SCORE_BITS+2)'(ref_level);
    diff_mag = diff[SCORE_BITS+1] ? (SCORE_BITS+2)'(-diff) : (SCORE_BITS+2)'(diff);
    score_sat = (diff_mag[SCORE_BITS+1:SCORE_BITS] != 2'b00) ? '1
                                                            : diff_mag[SCORE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (gram_tally == '0) begin
        res_score <= '0;
        res_total <= '0;
        res_short <= 1'b1;
      end else begin
        res_score <= score_sat;
        res_total <= gram_tally;
        res_short <= 1'b0;
      end
    end
  end

  assign result.valid      = res_valid;
  assign result.score      = res_score;
  assign result.gram_total = res_total;
  assign result.too_short  = res_short;

  always_comb begin
    status.letter_req = item.valid && (item.kind == KIND_LETTER);
    status.last_flag  = last_flag;
    status.tally_zero = (gram_tally == '0);
    status.div_done   = div_done;
    status.out_free   = !res_valid || result.ready;
  end

endmodule

>>> hdl/substitution_decrypt_quadgram_score_unit.sv
// Quadgram fitness scorer for substitution-cipher decryption, top level.
// Depends on sdq_pkg, sdq_item_if, sdq_result_if, sdq_ctrl and sdq_datapath.
//
// The item channel carries three kinds of words. Table writes load one entry
// of the 456976-entry log-probability memory and key writes load one entry of
// the inverse key; they can stream back to back while the unit is idle.
// Every table entry and key entry that a text will touch must be written
// before that text is scored. A ciphertext letter takes three steps: it is
// mapped through the key, the window index reads the table memory, and the
// entry is added to the running sum. A letter marked last then runs the
// bit-serial divider unless the tally is zero. The result channel holds one
// registered word; while the receiver stalls, items are still taken up to a
// further last letter, and none after it until the held word is taken. The
// ref_level register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the unit is idle, which the block does not enforce.
// Reset clears the controller, window, sum, tally, ref_level and result valid;
// the table memory and the key keep their contents and need no clearing pass.
module substitution_decrypt_quadgram_score_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  sdq_pkg::ref_t cfg_wr_data,
  sdq_item_if.sink      item,
  sdq_result_if.source  result
);
  import sdq_pkg::*;

  cmd_t    cmd;
  status_t status;

  sdq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sdq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .result      (result)
  );

endmodule

>>> hdl/sdq_checker.sv
// Port-level checks for the quadgram score unit, bound to the top level.
// Depends on sdq_pkg.
module sdq_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input sdq_pkg::kind_t item_kind,
  input logic           result_valid,
  input logic           result_ready,
  input sdq_pkg::score_t result_score,
  input sdq_pkg::gram_t result_gram_total,
  input logic           result_too_short
);
  import sdq_pkg::*;

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_score)
      && $stable(result_gram_total) && $stable(result_too_short))
    else $error("Result word changed while stalled.");

  a_short_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_too_short |-> (result_score == '0) && (result_gram_total == '0))
    else $error("Short text result carries a score or a count.");

  a_count_present: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_too_short |-> (result_gram_total != '0))
    else $error("Scored text reports no quadgrams.");

  a_letter_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_kind == KIND_LETTER) |=> !item_ready)
    else $error("Letter accepted without the lookup cycle.");

endmodule

bind substitution_decrypt_quadgram_score_unit sdq_checker u_sdq_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_kind         (item.kind),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_score      (result.score),
  .result_gram_total (result.gram_total),
  .result_too_short  (result.too_short)
);

>>> verif/substitution_decrypt_quadgram_score_unit_test.sv
// Self-checking test of the quadgram score unit. Predicts each text's fitness
// word from a local copy of the key, the table and the window state.
// Depends on sdq_pkg, sdq_item_if, sdq_result_if and the unit's top level.
`timescale 1ns / 100ps

module substitution_decrypt_quadgram_score_unit_test;
  import sdq_pkg::*;

  typedef struct packed {
    kind_t        kind;
    table_index_t table_index;
    value_t       table_value;
    letter_t      key_position;
    letter_t      key_letter;
    letter_t      letter;
    logic         last;
  } item_word_t;

  typedef struct packed {
    score_t score;
    gram_t  gram_total;
    logic   too_short;
  } fitness_t;

  localparam value_t  VALUE_TOP    = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam value_t  VALUE_BOTTOM = {1'b1, {(VALUE_BITS - 1){1'b0}}};
  localparam ref_t    REF_TOP      = {1'b0, {(REF_BITS - 1){1'b1}}};
  localparam ref_t    REF_BOTTOM   = {1'b1, {(REF_BITS - 1){1'b0}}};
  localparam letter_t LETTER_TOP   = '1;
  localparam longint  SCORE_CEIL   = (longint'(1) << SCORE_BITS) - 1;
  localparam int      LONG_TEXT    = 150;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  ref_t cfg_wr_data;

  sdq_item_if   item_ch ();
  sdq_result_if result_ch ();

  substitution_decrypt_quadgram_score_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item       (item_ch),
    .result     (result_ch)
  );

  value_t   log_memory [int];
  letter_t  key_map [ALPHABET_SIZE] = '{default: '0};
  logic [3*LETTER_BITS-1:0] window = '0;
  seen_t    window_fill = '0;
  longint   running_sum = 0;
  int       gram_count = 0;
  ref_t     ref_now = '0;

  fitness_t expected_fitness [$];
  letter_t  text_buf [$];
  letter_t  alphabet [3];
  int       mismatches = 0;
  int       effective_words = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gram_of(input letter_t a, b, c, d);
    return ((int'(a) * ALPHABET_SIZE + int'(b)) * ALPHABET_SIZE + int'(c)) * ALPHABET_SIZE
           + int'(d);
  endfunction

  function automatic void predict_fitness(input item_word_t w);
    letter_t  c;
    letter_t  p;
    int       gram;
    longint   avg;
    longint   diff;
    fitness_t r;
    case (w.kind)
      KIND_TABLE: begin
        if (w.table_index < TABLE_DEPTH) begin
          log_memory[int'(w.table_index)] = w.table_value;
          effective_words++;
        end
      end
      KIND_KEY: begin
        if (w.key_position <= LETTER_MAX && w.key_letter <= LETTER_MAX) begin
          key_map[w.key_letter] = w.key_position;
          effective_words++;
        end
      end
      KIND_LETTER: begin
        effective_words++;
        c = (w.letter > LETTER_MAX) ? LETTER_MAX : w.letter;
        p = key_map[c];
        if (window_fill == SEEN_FULL) begin
          gram = gram_of(window[14:10], window[9:5], window[4:0], p);
          if (gram_count < GRAM_CAP) begin
            if (log_memory.exists(gram)) running_sum += log_memory[gram];
            gram_count++;
          end
        end else begin
          window_fill++;
        end
        window = {window[9:0], p};
        if (w.last) begin
          if (gram_count == 0) begin
            r = '{score: '0, gram_total: '0, too_short: 1'b1};
          end else begin
            avg = running_sum / gram_count;
            diff = avg - longint'(ref_now);
            if (diff < 0) diff = -diff;
            if (diff > SCORE_CEIL) diff = SCORE_CEIL;
            r = '{score: score_t'(diff), gram_total: gram_t'(gram_count), too_short: 1'b0};
          end
          expected_fitness.insert(expected_fitness.size(), r);
          window = '0;
          window_fill = '0;
          running_sum = 0;
          gram_count = 0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    fitness_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_fitness.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, actual score %0d gram_total %0d too_short %0b",
                 $time, result_ch.score, result_ch.gram_total, result_ch.too_short);
      end else begin
        want = expected_fitness.pop_front();
        if (result_ch.score !== want.score || result_ch.gram_total !== want.gram_total ||
            result_ch.too_short !== want.too_short) begin
          mismatches++;
          $display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b (score/count/short)",
                   $time, want.score, want.gram_total, want.too_short,
                   result_ch.score, result_ch.gram_total, result_ch.too_short);
        end
      end
    end
  end

  task automatic send_word(input item_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= w.kind;
    item_ch.table_index  <= w.table_index;
    item_ch.table_value  <= w.table_value;
    item_ch.key_position <= w.key_position;
    item_ch.key_letter   <= w.key_letter;
    item_ch.letter       <= w.letter;
    item_ch.last         <= w.last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_fitness(w);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_fitness.size() != 0) @(posedge clk);
  endtask

  task automatic settle_unit();
    drain_results();
    repeat (60) @(posedge clk);
  endtask

  task automatic write_ref(input ref_t v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ref_now = v;
  endtask

  function automatic item_word_t random_word();
    item_word_t w;
    w.kind         = kind_t'($urandom);
    w.table_index  = table_index_t'($urandom);
    w.table_value  = value_t'($urandom);
    w.key_position = letter_t'($urandom);
    w.key_letter   = letter_t'($urandom);
    w.letter       = letter_t'($urandom);
    w.last         = $urandom_range(1);
    return w;
  endfunction

  function automatic item_word_t table_word(input table_index_t idx, input value_t v);
    item_word_t w = random_word();
    w.kind        = KIND_TABLE;
    w.table_index = idx;
    w.table_value = v;
    return w;
  endfunction

  function automatic item_word_t key_word(input letter_t pos, input letter_t cl);
    item_word_t w = random_word();
    w.kind         = KIND_KEY;
    w.key_position = pos;
    w.key_letter   = cl;
    return w;
  endfunction

  function automatic item_word_t letter_word(input letter_t l, input logic fin);
    item_word_t w = random_word();
    w.kind   = KIND_LETTER;
    w.letter = l;
    w.last   = fin;
    return w;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(7))
      0: return VALUE_TOP;
      1: return VALUE_BOTTOM;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Noise never maps a cipher letter outside the loaded alphabet, so no text
  // ever reaches a table entry that was not written.
  function automatic item_word_t noise_word();
    item_word_t w = random_word();
    case ($urandom_range(3))
      0: w.kind = ~KIND_TABLE;
      1: w = table_word(table_index_t'($urandom), pick_value());
      2: begin
        if ($urandom_range(1))
          w = key_word(letter_t'($urandom_range(26, 31)), letter_t'($urandom));
        else
          w = key_word(letter_t'($urandom), letter_t'($urandom_range(26, 31)));
      end
      default: w = key_word(alphabet[$urandom_range(2)], letter_t'($urandom_range(25)));
    endcase
    return w;
  endfunction

  task automatic load_alphabet(input letter_t a, input letter_t b, input letter_t c);
    letter_t pos;
    alphabet = '{a, b, c};
    for (int cl = 0; cl < ALPHABET_SIZE; cl++) begin
      pos = (cl == 0) ? a : (cl == ALPHABET_SIZE - 1) ? c : alphabet[$urandom_range(2)];
      send_word(key_word(pos, letter_t'(cl)));
    end
    for (int i = 0; i < 81; i++)
      send_word(table_word(table_index_t'(gram_of(alphabet[i / 27], alphabet[(i / 9) % 3],
                                                   alphabet[(i / 3) % 3], alphabet[i % 3])),
                           pick_value()));
  endtask

  task automatic add_letters(input letter_t l, input int n);
    repeat (n) text_buf.insert(text_buf.size(), l);
  endtask

  task automatic send_text(input int noise_pct);
    for (int i = 0; i < text_buf.size(); i++) begin
      if ($urandom_range(99) < noise_pct) send_word(noise_word());
      send_word(letter_word(text_buf[i], i == text_buf.size() - 1));
    end
    text_buf.delete();
  endtask

  task automatic test_short_and_extreme_texts();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    load_alphabet('0, letter_t'(13), LETTER_MAX);
    send_word(table_word('0, VALUE_TOP));
    send_word(table_word(table_index_t'(TABLE_DEPTH - 1), VALUE_BOTTOM));
    send_word(table_word(table_index_t'(TABLE_DEPTH), value_t'($urandom)));
    send_word(table_word('1, value_t'($urandom)));
    send_word(key_word(LETTER_TOP, '0));
    send_word(key_word('0, LETTER_TOP));
    send_word(noise_word() & ~item_word_t'(0) | item_word_t'(0));
    add_letters('0, 1);
    send_text(0);
    add_letters('0, 2);
    add_letters(LETTER_TOP, 1);
    send_text(0);
    add_letters('0, 4);
    send_text(0);
    add_letters(LETTER_TOP, 1);
    add_letters(LETTER_MAX, 3);
    send_text(0);
    add_letters('0, 4);
    add_letters(LETTER_MAX, 1);
    send_text(0);
    drain_results();
  endtask

  task automatic test_reference_extremes();
    settle_unit();
    write_ref(REF_BOTTOM);
    add_letters('0, 4);
    send_text(0);
    settle_unit();
    write_ref(REF_TOP);
    add_letters(LETTER_MAX, 4);
    send_text(0);
    add_letters('0, 4);
    send_text(0);
    drain_results();
  endtask

  task automatic test_long_text();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    settle_unit();
    write_ref(ref_t'($urandom));
    repeat (LONG_TEXT) text_buf.insert(text_buf.size(), letter_t'($urandom));
    send_text(0);
    add_letters(letter_t'($urandom), 5);
    send_text(0);
    drain_results();
  endtask

  task automatic test_random_texts(input int idle_pct, input int stall_pct);
    int      start;
    int      len;
    letter_t a;
    letter_t b;
    letter_t c;
    settle_unit();
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    write_ref(ref_t'($urandom));
    do begin
      a = letter_t'($urandom_range(25));
      b = letter_t'($urandom_range(25));
      c = letter_t'($urandom_range(25));
    end while (a == b || b == c || a == c);
    start = effective_words;
    load_alphabet(a, b, c);
    while (effective_words - start < 330) begin
      if ($urandom_range(19) == 0) drain_results();
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
      repeat (len) text_buf.insert(text_buf.size(), letter_t'($urandom));
      send_text(10);
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_TABLE;
    item_ch.table_index = '0;
    item_ch.table_value = '0;
    item_ch.key_position = '0;
    item_ch.key_letter = '0;
    item_ch.letter = '0;
    item_ch.last = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_and_extreme_texts();
    test_reference_extremes();
    test_long_text();
    test_random_texts(0, 0);
    test_random_texts(58, 0);
    test_random_texts(0, 58);
    test_random_texts(26, 26);

    settle_unit();
    if (mismatches == 0 && expected_fitness.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
